// ===== rtl/meter_reading_rate_plausibility_defines.svh =====
// Assertion macros used by the controller of the rate plausibility block.
`ifndef METER_READING_RATE_PLAUSIBILITY_DEFINES_SVH
`define METER_READING_RATE_PLAUSIBILITY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check b in the same cycle as a.
`define MRRP_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("rate plausibility: same-cycle check failed");

// Check b in the cycle after a.
`define MRRP_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("rate plausibility: next-cycle check failed");

`else

`define MRRP_ASSERT_SAME(label, clk, rst_n, a, b)
`define MRRP_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/mrrp_pkg.sv =====
package mrrp_pkg;

	localparam int VALUE_WIDTH    = 32;
	localparam int STAMP_WIDTH    = 32;
	localparam int MINUTE_SECONDS = 60;
	// |diff| < 2^33, times 60 fits in 39 bits
	localparam int DIV_W          = 39;
	localparam int CNT_W          = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 31;
	localparam int MAX_RATE_W     = 31;

	localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] MIN_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_CHECK_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NEGATIVE  = 2'd3;

	// Rate check modes (the fourth code checks the interval rate)
	localparam logic [1:0] CHECK_MODE_OFF      = 2'd0;
	localparam logic [1:0] CHECK_MODE_INTERVAL = 2'd1;
	localparam logic [1:0] CHECK_MODE_MINUTE   = 2'd2;

	// Opcodes
	localparam logic OP_READING = 1'b0;
	localparam logic OP_PRESET  = 1'b1;

	// Status codes
	localparam logic [2:0] ST_VALID          = 3'd0;
	localparam logic [2:0] ST_EMPTY          = 3'd1;
	localparam logic [2:0] ST_NEGATIVE       = 3'd2;
	localparam logic [2:0] ST_TOO_HIGH_NEG   = 3'd3;
	localparam logic [2:0] ST_TOO_HIGH_POS   = 3'd4;
	localparam logic [2:0] ST_PRESET_OK      = 3'd5;
	localparam logic [2:0] ST_PRESET_REFUSED = 3'd6;

	typedef struct packed {
		logic                          opcode;
		logic signed [VALUE_WIDTH-1:0] reading;
		logic [STAMP_WIDTH-1:0]        stamp;
		logic                          has_data;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] actual_value;
		logic                          confirmed;
		logic signed [VALUE_WIDTH-1:0] rate_interval;
		logic signed [VALUE_WIDTH-1:0] rate_minute;
		logic signed [VALUE_WIDTH-1:0] fallback_out;
		logic [2:0]                    status;
		logic                          warn_event;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/mrrp_div.sv =====
module mrrp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mrrp_pkg::DIV_W-1:0]   dividend,
	input  logic [mrrp_pkg::STAMP_WIDTH-1:0] divisor,
	output logic                         busy,
	output logic [mrrp_pkg::DIV_W-1:0]   quotient
);
	import mrrp_pkg::*;

	logic [CNT_W-1:0]       cnt_q;
	logic [STAMP_WIDTH-1:0] rem_q;
	logic [STAMP_WIDTH-1:0] dvs_q;
	logic [DIV_W-1:0]       quo_q;
	logic [STAMP_WIDTH:0]   shifted;
	logic [STAMP_WIDTH+1:0] trial;
	logic                   fits;

	// One restoring step: shift in the next dividend bit, try to subtract.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !trial[STAMP_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= fits ? trial[STAMP_WIDTH-1:0] : shifted[STAMP_WIDTH-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = |cnt_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/mrrp_dp.sv =====
module mrrp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mrrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrrp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  mrrp_pkg::in_item_t                 in_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output mrrp_pkg::out_item_t                out_data,
	input  mrrp_pkg::dp_cmd_t                  cmd,
	output mrrp_pkg::dp_sts_t                  sts,
	output logic [mrrp_pkg::DIV_W-1:0]         div_dividend,
	output logic [mrrp_pkg::STAMP_WIDTH-1:0]   div_divisor,
	input  logic [mrrp_pkg::DIV_W-1:0]         div_quotient
);
	import mrrp_pkg::*;

	function automatic logic [VALUE_WIDTH-1:0] sat_mag(input logic neg,
			input logic [DIV_W-1:0] mag);
		logic [VALUE_WIDTH-1:0] res;
		if (!neg) begin
			res = (mag > DIV_W'(MAX_POS)) ? MAX_POS : mag[VALUE_WIDTH-1:0];
		end else begin
			res = (mag > DIV_W'(MIN_NEG)) ? MIN_NEG : -mag[VALUE_WIDTH-1:0];
		end
		return res;
	endfunction

	// Configuration
	logic                  fb_en_q;
	logic [1:0]            mode_q;
	logic [MAX_RATE_W-1:0] max_rate_q;
	logic                  allow_neg_q;

	// Fallback state
	logic signed [VALUE_WIDTH-1:0] fv_q;
	logic [STAMP_WIDTH-1:0]        ft_q;
	logic                          fvalid_q;
	logic signed [VALUE_WIDTH-1:0] last_raw_q;

	in_item_t  in_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic signed [VALUE_WIDTH:0]   diff;
	logic                          diff_neg;
	logic [VALUE_WIDTH:0]          diff_mag;
	logic [STAMP_WIDTH-1:0]        dt;
	logic                          dt_zero;
	logic [DIV_W-1:0]              q_mag;
	logic                          pm_neg;
	logic                          per_min;
	logic [DIV_W-1:0]              chk_mag;
	logic                          chk_neg;
	logic                          over;

	logic signed [VALUE_WIDTH-1:0] fv_n;
	logic [STAMP_WIDTH-1:0]        ft_n;
	logic                          fvalid_n;
	logic signed [VALUE_WIDTH-1:0] last_raw_n;
	out_item_t                     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_en_q     <= 1'b0;
			mode_q      <= CHECK_MODE_OFF;
			max_rate_q  <= '0;
			allow_neg_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FALLBACK_ENABLE: fb_en_q     <= cfg_data[0];
				REG_RATE_CHECK_MODE: mode_q      <= cfg_data[1:0];
				REG_MAX_RATE:        max_rate_q  <= cfg_data[MAX_RATE_W-1:0];
				REG_ALLOW_NEGATIVE:  allow_neg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
	end

	// Operands for the minute rate divide
	assign diff     = {in_q.reading[VALUE_WIDTH-1], in_q.reading} - {fv_q[VALUE_WIDTH-1], fv_q};
	assign diff_neg = diff[VALUE_WIDTH];
	assign diff_mag = diff_neg ? -diff : diff;
	assign dt       = (in_q.stamp >= ft_q) ? (in_q.stamp - ft_q) : (ft_q - in_q.stamp);
	assign dt_zero  = (dt == '0);

	assign div_dividend = DIV_W'(diff_mag) * DIV_W'(MINUTE_SECONDS);
	assign div_divisor  = dt;

	assign q_mag   = dt_zero ? '0 : div_quotient;
	assign pm_neg  = diff_neg && (q_mag != '0);
	assign per_min = (mode_q == CHECK_MODE_MINUTE);
	assign chk_mag = per_min ? q_mag : DIV_W'(diff_mag);
	assign chk_neg = per_min ? pm_neg : diff_neg;
	assign over    = (mode_q != CHECK_MODE_OFF) && (chk_mag > DIV_W'(max_rate_q));

	always_comb begin
		fv_n       = fv_q;
		ft_n       = ft_q;
		fvalid_n   = fvalid_q;
		last_raw_n = last_raw_q;
		res        = '0;
		res.status = ST_VALID;
		if (in_q.opcode == OP_PRESET) begin
			if (!in_q.reading[VALUE_WIDTH-1] || (last_raw_q != '0)) begin
				fv_n       = in_q.reading[VALUE_WIDTH-1] ? last_raw_q : in_q.reading;
				ft_n       = in_q.stamp;
				fvalid_n   = 1'b1;
				res.status = ST_PRESET_OK;
			end else begin
				res.status = ST_PRESET_REFUSED;
			end
		end else if (!in_q.has_data) begin
			last_raw_n = '0;
			res.status = ST_EMPTY;
		end else begin
			last_raw_n       = in_q.reading;
			res.actual_value = in_q.reading;
			res.confirmed    = 1'b1;
			if (!fb_en_q) begin
				fv_n = '0;
			end else begin
				if (fvalid_q) begin
					res.rate_interval = sat_mag(diff_neg, DIV_W'(diff_mag));
					res.rate_minute   = sat_mag(pm_neg, q_mag);
					if (over) begin
						res.confirmed  = 1'b0;
						res.status     = chk_neg ? ST_TOO_HIGH_NEG : ST_TOO_HIGH_POS;
						res.warn_event = 1'b1;
						if (chk_neg) begin
							ft_n = in_q.stamp;
						end
					end
					if (!allow_neg_q && res.confirmed && diff_neg) begin
						res.confirmed = 1'b0;
						res.status    = ST_NEGATIVE;
						ft_n          = in_q.stamp;
					end
				end
				if (res.confirmed) begin
					fv_n       = in_q.reading;
					ft_n       = in_q.stamp;
					fvalid_n   = 1'b1;
					res.status = ST_VALID;
				end else begin
					res.rate_interval = '0;
					res.rate_minute   = '0;
					res.actual_value  = fv_q;
				end
			end
		end
		res.fallback_out = fb_en_q ? fv_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q       <= '0;
			ft_q       <= '0;
			fvalid_q   <= 1'b0;
			last_raw_q <= '0;
		end else if (cmd.commit) begin
			fv_q       <= fv_n;
			ft_q       <= ft_n;
			fvalid_q   <= fvalid_n;
			last_raw_q <= last_raw_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

// ===== rtl/mrrp_ctrl.sv =====
`include "meter_reading_rate_plausibility_defines.svh"

module mrrp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              div_busy,
	input  mrrp_pkg::dp_sts_t sts,
	output mrrp_pkg::dp_cmd_t cmd
);
	import mrrp_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		START,
		WAIT_DIV,
		FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= START;
					end
				end
				START: begin
					state_q <= WAIT_DIV;
				end
				WAIT_DIV: begin
					if (!div_busy) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == IDLE);
	assign cmd.load      = in_valid && in_ready;
	assign cmd.div_start = (state_q == START);
	assign cmd.commit    = (state_q == FINISH) && sts.out_free;

	`MRRP_ASSERT_SAME(a_idle_div_quiet, clk, arst_n, in_ready, !div_busy)
	`MRRP_ASSERT_NEXT(a_accept_starts_div, clk, arst_n, cmd.load, cmd.div_start)
	`MRRP_ASSERT_SAME(a_commit_after_div, clk, arst_n, cmd.commit, !div_busy && !cmd.load)

endmodule

// ===== rtl/meter_reading_rate_plausibility.sv =====
// Meter reading rate plausibility check. Each request carries a reading (or a
// preset) and produces exactly one result; requests are handled one at a time.
// After a request is taken, the START state starts the restoring divider for
// the rate per minute, which retires one quotient bit per cycle over 39 bits;
// the WAIT_DIV state sees it finish and the FINISH state writes the verdict
// into the output register. A new request is taken once the previous verdict
// sits in the output register, even if it is not yet taken; a result left
// waiting holds back the verdict of the next request. Configuration registers
// (fallback enable, rate check mode, maximum rate, allow negative) are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while
// no request is in flight, and the block itself does not enforce this.
module meter_reading_rate_plausibility (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mrrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrrp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mrrp_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output mrrp_pkg::out_item_t             out_data
);
	import mrrp_pkg::*;

	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic                   div_busy;
	logic [DIV_W-1:0]       div_dividend;
	logic [STAMP_WIDTH-1:0] div_divisor;
	logic [DIV_W-1:0]       div_quotient;

	// Sequence each request: capture, divide, commit the verdict.
	mrrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.div_busy (div_busy),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold configuration, fallback state and the result register; decide.
	mrrp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_data      (in_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_data     (out_data),
		.cmd          (cmd),
		.sts          (sts),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_quotient (div_quotient)
	);

	// |difference| * 60 over elapsed seconds, one bit per cycle.
	mrrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

endmodule
